// ----- hdl/atpll_pkg.sv -----
// Shared types and constants for the angle tracking PLL.
package atpll_pkg;

	localparam int ANG_W   = 16;
	localparam int GAIN_W  = 32;
	localparam int TICK_W  = 32;
	localparam int INTEG_W = 48;
	localparam int SPD_W   = 49;
	localparam int MUL_W   = 32;
	localparam int PROD_W  = 64;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD   = 2'd2;

	localparam logic [TICK_W-1:0] TICK_PERIOD_RST = 32'd214748;

	localparam logic [GAIN_W-1:0] SPD_OUT_MAX = 32'h7FFF_FFFF;
	localparam logic [GAIN_W-1:0] SPD_OUT_MIN = 32'h8000_0000;

	localparam logic [INTEG_W-1:0] INTEG_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [INTEG_W-1:0] INTEG_MIN = 48'h8000_0000_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KI,
		ST_LO1,
		ST_HI1,
		ST_INTEG,
		ST_SPEED,
		ST_ABS,
		ST_LO2,
		ST_HI2,
		ST_ANGLE
	} state_t;

endpackage

// ----- hdl/atpll_mul.sv -----
// Shared 32 x 32 unsigned multiplier with registered product.
module atpll_mul (
	input  logic                             clk,
	input  logic [atpll_pkg::MUL_W-1:0]      a,
	input  logic [atpll_pkg::MUL_W-1:0]      b,
	output logic [atpll_pkg::PROD_W-1:0]     prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= {{(atpll_pkg::PROD_W-atpll_pkg::MUL_W){1'b0}}, a}
			* {{(atpll_pkg::PROD_W-atpll_pkg::MUL_W){1'b0}}, b};
	end

endmodule

// ----- hdl/angle_tracking_pll_top.sv -----
// Top level of the PI angle tracking PLL: sequencer, loop state and ports.
//
// One measured angle is accepted when in_ready is high; the block then runs nine
// sequencer steps around a single shared 32 x 32 multiplier (gain times error,
// two partial products for the tick scaling of the integrator increment, the
// proportional term, two partial products for the angle advance), with the
// integrator add/saturate, the speed add, the speed magnitude and the angle
// update folded into those steps. A new item is taken only when the sequencer
// is back in idle, after the last step of the previous item. The result sits in
// an output register with out_valid; the next item may be accepted while it
// waits, and the last step of that item holds until the previous result has been
// taken. Configuration writes are always ready and take effect immediately;
// write them only while the block is idle.
module angle_tracking_pll_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [atpll_pkg::ANG_W-1:0]           measured_angle,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [atpll_pkg::ANG_W-1:0]           estimated_angle,
	output logic signed [atpll_pkg::GAIN_W-1:0]   speed_estimate,
	output logic signed [atpll_pkg::ANG_W-1:0]    phase_error,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [atpll_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [atpll_pkg::GAIN_W-1:0]          cfg_data
);

	atpll_pkg::state_t state_q, state_d;

	logic [atpll_pkg::GAIN_W-1:0]  prop_gain_q;
	logic [atpll_pkg::GAIN_W-1:0]  integral_gain_q;
	logic [atpll_pkg::TICK_W-1:0]  tick_period_q;
	logic [atpll_pkg::INTEG_W-1:0] integ_q;
	logic [atpll_pkg::ANG_W-1:0]   tracked_q;

	logic [atpll_pkg::ANG_W-1:0]   err_q;
	logic [15:0]                   p1_hi_q;
	logic [31:0]                   carry_q;
	logic [atpll_pkg::SPD_W-1:0]   speed_q;
	logic [47:0]                   spd_mag_q;
	logic [atpll_pkg::GAIN_W-1:0]  whole_q;
	logic                          out_valid_q;

	logic [atpll_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic [atpll_pkg::PROD_W-1:0]  prod_q;

	logic [atpll_pkg::ANG_W-1:0]   err_neg, err_abs;
	logic [atpll_pkg::GAIN_W-1:0]  ki_neg, ki_abs, kp_neg, kp_abs;
	logic                          inc_sign, prop_sign;
	logic [47:0]                   inc_mag;
	logic [49:0]                   inc_val, integ_sum;
	logic [atpll_pkg::INTEG_W-1:0] integ_sat;
	logic [atpll_pkg::SPD_W-1:0]   prop_val, speed_sum, speed_neg;
	logic [31:0]                   whole_mag, whole_neg, whole_sat;
	logic [48:0]                   adv_acc;
	logic [atpll_pkg::ANG_W-1:0]   adv_mag, adv_val;
	logic                          fire_in, finish;

	atpll_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign in_ready  = (state_q == atpll_pkg::ST_IDLE);
	assign fire_in   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign finish    = (state_q == atpll_pkg::ST_ANGLE) && (!out_valid_q || out_ready);

	// Magnitudes and signs for the sign-magnitude multiplies
	assign err_neg   = -err_q;
	assign err_abs   = err_q[atpll_pkg::ANG_W-1] ? err_neg : err_q;
	assign ki_neg    = -integral_gain_q;
	assign ki_abs    = integral_gain_q[atpll_pkg::GAIN_W-1] ? ki_neg : integral_gain_q;
	assign kp_neg    = -prop_gain_q;
	assign kp_abs    = prop_gain_q[atpll_pkg::GAIN_W-1] ? kp_neg : prop_gain_q;
	assign inc_sign  = integral_gain_q[atpll_pkg::GAIN_W-1] ^ err_q[atpll_pkg::ANG_W-1];
	assign prop_sign = prop_gain_q[atpll_pkg::GAIN_W-1] ^ err_q[atpll_pkg::ANG_W-1];

	// Integrator increment: high partial product plus carried-down low part
	assign inc_mag   = prod_q[47:0] + {16'b0, carry_q};
	assign inc_val   = inc_sign ? -{2'b0, inc_mag} : {2'b0, inc_mag};
	assign integ_sum = {{2{integ_q[atpll_pkg::INTEG_W-1]}}, integ_q} + inc_val;

	always_comb begin
		if (!integ_sum[49] && (integ_sum[48] || integ_sum[47])) begin
			integ_sat = atpll_pkg::INTEG_MAX;
		end else if (integ_sum[49] && !(integ_sum[48] && integ_sum[47])) begin
			integ_sat = atpll_pkg::INTEG_MIN;
		end else begin
			integ_sat = integ_sum[47:0];
		end
	end

	assign prop_val  = prop_sign ? -{2'b0, prod_q[46:0]} : {2'b0, prod_q[46:0]};
	assign speed_sum = prop_val + {integ_q[atpll_pkg::INTEG_W-1], integ_q};
	assign speed_neg = -speed_q;

	// Integer part of the speed, toward zero, clamped to 32 bits
	assign whole_mag = spd_mag_q[47:16];
	assign whole_neg = -whole_mag;
	always_comb begin
		if (!speed_q[atpll_pkg::SPD_W-1]) begin
			whole_sat = whole_mag[31] ? atpll_pkg::SPD_OUT_MAX : whole_mag;
		end else if (whole_mag > atpll_pkg::SPD_OUT_MIN) begin
			whole_sat = atpll_pkg::SPD_OUT_MIN;
		end else begin
			whole_sat = whole_neg;
		end
	end

	// Angle advance: keep bits 31:16 of the scaled speed magnitude, wrap
	assign adv_acc = prod_q[48:0] + {17'b0, carry_q};
	assign adv_mag = adv_acc[31:16];
	assign adv_val = speed_q[atpll_pkg::SPD_W-1] ? -adv_mag : adv_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atpll_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = tick_period_q;
		case (state_q)
			atpll_pkg::ST_IDLE: begin
				if (in_valid) state_d = atpll_pkg::ST_KI;
			end
			atpll_pkg::ST_KI: begin
				mul_a   = ki_abs;
				mul_b   = {16'b0, err_abs};
				state_d = atpll_pkg::ST_LO1;
			end
			atpll_pkg::ST_LO1: begin
				mul_a   = prod_q[31:0];
				state_d = atpll_pkg::ST_HI1;
			end
			atpll_pkg::ST_HI1: begin
				mul_a   = {16'b0, p1_hi_q};
				state_d = atpll_pkg::ST_INTEG;
			end
			atpll_pkg::ST_INTEG: begin
				mul_a   = kp_abs;
				mul_b   = {16'b0, err_abs};
				state_d = atpll_pkg::ST_SPEED;
			end
			atpll_pkg::ST_SPEED: begin
				state_d = atpll_pkg::ST_ABS;
			end
			atpll_pkg::ST_ABS: begin
				state_d = atpll_pkg::ST_LO2;
			end
			atpll_pkg::ST_LO2: begin
				mul_a   = spd_mag_q[31:0];
				state_d = atpll_pkg::ST_HI2;
			end
			atpll_pkg::ST_HI2: begin
				mul_a   = {16'b0, spd_mag_q[47:32]};
				state_d = atpll_pkg::ST_ANGLE;
			end
			atpll_pkg::ST_ANGLE: begin
				// keep the high partial product steady while the result waits
				mul_a   = {16'b0, spd_mag_q[47:32]};
				// hold until the previous result has left the output register
				if (!out_valid_q || out_ready) state_d = atpll_pkg::ST_IDLE;
			end
			default: begin
				state_d = atpll_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= '0;
			integral_gain_q <= '0;
			tick_period_q   <= atpll_pkg::TICK_PERIOD_RST;
			integ_q         <= '0;
			tracked_q       <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					atpll_pkg::CFG_PROP_GAIN:     prop_gain_q     <= cfg_data;
					atpll_pkg::CFG_INTEGRAL_GAIN: integral_gain_q <= cfg_data;
					atpll_pkg::CFG_TICK_PERIOD:   tick_period_q   <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == atpll_pkg::ST_INTEG) integ_q <= integ_sat;
			if (finish) begin
				tracked_q   <= tracked_q + adv_val;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_in) err_q <= measured_angle - tracked_q;
		if (state_q == atpll_pkg::ST_LO1) p1_hi_q <= prod_q[47:32];
		if (state_q == atpll_pkg::ST_HI1 || state_q == atpll_pkg::ST_HI2) begin
			carry_q <= prod_q[63:32];
		end
		if (state_q == atpll_pkg::ST_SPEED) speed_q <= speed_sum;
		if (state_q == atpll_pkg::ST_ABS) begin
			spd_mag_q <= speed_q[atpll_pkg::SPD_W-1] ? speed_neg[47:0] : speed_q[47:0];
		end
		if (state_q == atpll_pkg::ST_LO2) whole_q <= whole_sat;
		if (finish) begin
			estimated_angle <= tracked_q + adv_val;
			speed_estimate  <= whole_q;
			phase_error     <= err_q;
		end
	end

endmodule

// ----- hdl/atpll_chk.sv -----
// Port-level checker for the angle tracking PLL, bound to the top level.
module atpll_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [atpll_pkg::ANG_W-1:0]           estimated_angle,
	input logic signed [atpll_pkg::GAIN_W-1:0]   speed_estimate,
	input logic signed [atpll_pkg::ANG_W-1:0]    phase_error
);

	// an accepted beat keeps the block busy for the following cycles
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input taken again right after an accepted beat");

	// a new result only appears at the end of a busy stretch
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without work in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(estimated_angle)
			&& $stable(speed_estimate) && $stable(phase_error))
		else $error("stalled result beat changed");

endmodule

bind angle_tracking_pll_top atpll_chk u_atpll_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.estimated_angle (estimated_angle),
	.speed_estimate  (speed_estimate),
	.phase_error     (phase_error)
);
